// ===== design/kdh_pkg.sv =====
// ----------------------------------------------------------------------------
// kdh_pkg
// shared types and constants for the key debouncer with release hold-off
// ----------------------------------------------------------------------------
package kdh_pkg;

	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CONFIRM_THRESHOLD_RST = CNT_W'(3);
	localparam logic [CNT_W-1:0] HOLDOFF_RELOAD_RST = '0;

	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_RELOAD = CFG_IDX_W'(1);

	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	typedef struct packed {
		logic action;
		logic raw_level;
		logic clear_on_read;
	} kdh_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] confirm_threshold;
		logic [CNT_W-1:0] holdoff_reload;
	} kdh_cfg_t;

endpackage

// ===== design/kdh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kdh_cfg_regs
// configuration register file: confirm threshold and hold-off reload
// ----------------------------------------------------------------------------
module kdh_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [kdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdh_pkg::CNT_W-1:0] cfg_data,
	output logic                     cfg_ready,
	output kdh_pkg::kdh_cfg_t        cfg
);
	import kdh_pkg::*;

	kdh_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_threshold <= CONFIRM_THRESHOLD_RST;
			cfg_q.holdoff_reload <= HOLDOFF_RELOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CONFIRM_THRESHOLD) begin
				cfg_q.confirm_threshold <= cfg_data;
			end
			if (cfg_index == REG_HOLDOFF_RELOAD) begin
				cfg_q.holdoff_reload <= cfg_data;
			end
		end
	end

endmodule

// ===== design/kdh_input_stage.sv =====
// ----------------------------------------------------------------------------
// kdh_input_stage
// input register for one item beat, stalls only while it holds a beat and the result side is full and stalled
// ----------------------------------------------------------------------------
module kdh_input_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  kdh_pkg::kdh_item_t  in_item,
	output logic                in_stall,
	input  logic                advance,
	output logic                item_valid,
	output kdh_pkg::kdh_item_t  item
);
	import kdh_pkg::*;

	logic      valid_s1;
	kdh_item_t item_s1;

	assign in_stall = valid_s1 && !advance;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/kdh_core.sv =====
// ----------------------------------------------------------------------------
// kdh_core
// debounce state update and result register
// ----------------------------------------------------------------------------
module kdh_core (
	input  logic                clk,
	input  logic                arst_n,
	input  kdh_pkg::kdh_cfg_t   cfg,
	input  logic                item_valid,
	input  kdh_pkg::kdh_item_t  item,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                pressed
);
	import kdh_pkg::*;

	logic             state_q;
	logic [CNT_W-1:0] confirm_q;
	logic [CNT_W-1:0] holdoff_q;
	logic             out_valid_s2;
	logic             pressed_s2;

	logic             state_d;
	logic [CNT_W-1:0] confirm_d;
	logic [CNT_W-1:0] holdoff_d;
	logic [CNT_W-1:0] confirm_inc;
	logic             result;
	logic             fire;

	assign advance = !out_valid_s2 || !out_stall;
	assign fire = item_valid && advance;
	assign out_valid = out_valid_s2;
	assign pressed = pressed_s2;

	assign confirm_inc = (confirm_q == CNT_MAX) ? confirm_q : confirm_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		confirm_d = confirm_q;
		holdoff_d = holdoff_q;
		result = state_q;
		if (item.action == ACTION_QUERY) begin
			if (item.clear_on_read) begin
				state_d = 1'b0;
			end
		end else begin
			priority if (!state_q && holdoff_q != '0) begin
				holdoff_d = holdoff_q - CNT_W'(1);
			end else if (item.raw_level != state_q) begin
				if (confirm_inc >= cfg.confirm_threshold) begin
					state_d = !state_q;
					confirm_d = '0;
				end else begin
					confirm_d = confirm_inc;
				end
				if (state_d) begin
					holdoff_d = cfg.holdoff_reload;
				end
			end else begin
				if (confirm_q != '0) begin
					confirm_d = confirm_q - CNT_W'(1);
				end
			end
			result = state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 1'b0;
			confirm_q <= '0;
			holdoff_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_d;
				confirm_q <= confirm_d;
				holdoff_q <= holdoff_d;
			end
			if (advance) begin
				out_valid_s2 <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pressed_s2 <= result;
		end
	end

endmodule

// ===== design/key_debounce_with_holdoff.sv =====
// ----------------------------------------------------------------------------
// key_debounce_with_holdoff
// push-button debouncer with integrating confirm counter and release hold-off
// ----------------------------------------------------------------------------
// Each input beat is either a raw pin sample or a query of the debounced
// state, and each gives exactly one result beat, held in the input register
// and then in the result register. One beat is taken every cycle unless
// the input side stalls: the state update is a single 16-bit increment and
// compare between these two registers, and the counters feed back to
// themselves. The input side stalls only while both registers hold a beat
// and the output side stalls. Configuration writes are always ready and
// take effect on the next beat; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module key_debounce_with_holdoff (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic                          raw_level,
	input  logic                          clear_on_read,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pressed,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdh_pkg::CNT_W-1:0]     cfg_data
);
	import kdh_pkg::*;

	kdh_cfg_t  cfg;
	kdh_item_t in_item;
	kdh_item_t item;
	logic      item_valid;
	logic      advance;

	assign in_item.action = action;
	assign in_item.raw_level = raw_level;
	assign in_item.clear_on_read = clear_on_read;

	kdh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	kdh_input_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_item    (in_item),
		.in_stall   (in_stall),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	kdh_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pressed    (pressed)
	);

endmodule
